// ===== rtl/core/dsna_pkg.sv =====
package dsna_pkg;

	localparam int MAX_NAME_DEF = 128;
	localparam int OUT_MAX      = 12;
	localparam int BASE_MAX     = 8;
	localparam int EXT_MAX      = 3;

	localparam logic [63:0] FNV_BASIS  = 64'd1469598103934665603;
	// 36^4 = 6561 * 256: the low byte passes through, the rest is reduced mod 6561
	localparam logic [20:0] MOD_HI     = 21'd6561;
	// floor(x/6561) == (x * RECIP6561) >> 34 for any 21-bit x
	localparam logic [21:0] RECIP6561  = 22'd2618484;
	// floor(x/9) == (x * RECIP9) >> 22 for any 19-bit x
	localparam logic [18:0] RECIP9     = 19'd466034;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_USCR  = 8'h5F;

	localparam logic [7:0] EXTRA_CHARS [16] = '{
		8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
		8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26
	};

	// one classified name, handed from the front end to the back end
	typedef struct packed {
		logic                       fits;      // already a valid 8.3 name
		logic                       trunc;     // longer than the store
		logic [OUT_MAX-1:0][7:0]    chars;     // first stored bytes, upper-cased
		logic [3:0]                 n83;       // 8.3 output length
		logic [2:0][7:0]            base_c;    // first allowed base chars
		logic [1:0]                 base_n;
		logic [2:0][7:0]            ext_c;     // allowed chars after last dot
		logic [1:0]                 ext_n;
		logic [63:0]                identity;
		logic [63:0]                hash;
	} desc_t;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
	endfunction

	function automatic logic is_allowed(input logic [7:0] c);
		logic [7:0] u;
		logic       hit;
		u   = to_upper(c);
		hit = (u >= 8'h41 && u <= 8'h5A) || (u >= 8'h30 && u <= 8'h39) || u[7];
		for (int i = 0; i < 16; i++) begin
			if (u == EXTRA_CHARS[i]) hit = 1'b1;
		end
		return hit;
	endfunction

	// FNV-1a step; prime is 2^40 + 0x1B3, done as shifted adds
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

	function automatic logic [7:0] digit36(input logic [5:0] v);
		return (v < 6'd10) ? (8'h30 + {2'b00, v}) : (8'h41 + {2'b00, v} - 8'd10);
	endfunction

endpackage

// ===== rtl/core/dsna_front.sv =====
module dsna_front #(
	parameter int MAX_NAME = dsna_pkg::MAX_NAME_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        name_byte,
	input  logic              name_end,
	input  logic [63:0]       entry_identity,
	output logic              push,
	output dsna_pkg::desc_t   desc
);
	import dsna_pkg::*;

	localparam int LW = $clog2(MAX_NAME + 1);
	localparam logic [LW-1:0] LEN_MAX = LW'(MAX_NAME);
	localparam logic [LW-1:0] LEN_BUF = LW'(OUT_MAX);

	logic [LW-1:0]             len_q, len_d;
	logic [63:0]               hash_q, hash_d;
	logic [1:0]                dots_q, dots_d;
	logic                      dotnz_q, dotnz_d;
	logic                      trunc_q, trunc_d;
	logic                      bad_q, bad_d;
	logic [3:0]                tot_q, tot_d;
	logic [3:0]                extn_q, extn_d;
	logic [OUT_MAX-1:0][7:0]   chars_q, chars_d;
	logic [2:0][7:0]           bc_q, bc_d;
	logic [1:0]                bn_q, bn_d;
	logic [1:0]                bb_q, bb_d;
	logic [2:0][7:0]           ec_q, ec_d;
	logic [1:0]                en_q, en_d;

	always_comb begin
		logic [7:0] up;
		logic       isdot;
		logic       allow;
		logic [3:0] ext_cnt;
		logic [3:0] base_cnt;

		len_d   = len_q;
		dots_d  = dots_q;
		dotnz_d = dotnz_q;
		trunc_d = trunc_q;
		bad_d   = bad_q;
		tot_d   = tot_q;
		extn_d  = extn_q;
		chars_d = chars_q;
		bc_d    = bc_q;
		bn_d    = bn_q;
		bb_d    = bb_q;
		ec_d    = ec_q;
		en_d    = en_q;

		up     = to_upper(name_byte);
		isdot  = (name_byte == CH_DOT);
		allow  = is_allowed(name_byte);
		hash_d = fnv_step(hash_q, up);

		if (len_q < LEN_MAX) begin
			len_d = len_q + 1'b1;
			if (len_q < LEN_BUF) chars_d[len_q[3:0]] = up;
			if (isdot) begin
				if (dots_q != 2'd2) dots_d = dots_q + 2'd1;
				dotnz_d = (len_q != '0);
				bb_d    = bn_q;
				extn_d  = '0;
				en_d    = '0;
			end else begin
				if (tot_q != 4'hF) tot_d = tot_q + 4'd1;
				if (dots_q != 2'd0 && extn_q != 4'hF) extn_d = extn_q + 4'd1;
				if (!allow) bad_d = 1'b1;
				if (allow && bn_q != 2'd3) begin
					bc_d[bn_q] = up;
					bn_d       = bn_q + 2'd1;
				end
				if (allow && dots_q != 2'd0 && en_q != 2'd3) begin
					ec_d[en_q] = up;
					en_d       = en_q + 2'd1;
				end
			end
		end else begin
			trunc_d = 1'b1;
		end

		// classify on the values that include this byte
		ext_cnt  = (dots_d != 2'd0) ? extn_d : 4'd0;
		base_cnt = tot_d - ext_cnt;

		desc.fits     = (dots_d <= 2'd1) && !bad_d && !trunc_d && (base_cnt != 4'd0)
		                && (base_cnt <= 4'(BASE_MAX)) && (ext_cnt <= 4'(EXT_MAX));
		desc.trunc    = trunc_d;
		desc.chars    = chars_d;
		desc.n83      = base_cnt + ext_cnt + {3'd0, (ext_cnt != 4'd0)};
		desc.base_c   = bc_d;
		desc.base_n   = (dots_d != 2'd0 && dotnz_d) ? bb_d : bn_d;
		desc.ext_c    = ec_d;
		desc.ext_n    = en_d;
		desc.identity = entry_identity;
		desc.hash     = hash_d;
	end

	assign push = take && name_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			hash_q  <= FNV_BASIS;
			dots_q  <= '0;
			dotnz_q <= 1'b0;
			trunc_q <= 1'b0;
			bad_q   <= 1'b0;
			tot_q   <= '0;
			extn_q  <= '0;
			bn_q    <= '0;
			bb_q    <= '0;
			en_q    <= '0;
		end else if (take) begin
			if (name_end) begin
				len_q   <= '0;
				hash_q  <= FNV_BASIS;
				dots_q  <= '0;
				dotnz_q <= 1'b0;
				trunc_q <= 1'b0;
				bad_q   <= 1'b0;
				tot_q   <= '0;
				extn_q  <= '0;
				bn_q    <= '0;
				bb_q    <= '0;
				en_q    <= '0;
			end else begin
				len_q   <= len_d;
				hash_q  <= hash_d;
				dots_q  <= dots_d;
				dotnz_q <= dotnz_d;
				trunc_q <= trunc_d;
				bad_q   <= bad_d;
				tot_q   <= tot_d;
				extn_q  <= extn_d;
				bn_q    <= bn_d;
				bb_q    <= bb_d;
				en_q    <= en_d;
			end
		end
	end

	// character buffers are qualified by the counts above
	always_ff @(posedge clk) begin
		if (take) begin
			chars_q <= chars_d;
			bc_q    <= bc_d;
			ec_q    <= ec_d;
		end
	end

endmodule

// ===== rtl/core/dsna_queue.sv =====
module dsna_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dsna_pkg::desc_t   push_data,
	input  logic              pop,
	output logic              full,
	output logic              avail,
	output dsna_pkg::desc_t   pop_data
);
	import dsna_pkg::*;

	desc_t      mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign avail    = (cnt_q != 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

// ===== rtl/core/dsna_back.sv =====
module dsna_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              avail,
	input  dsna_pkg::desc_t   desc,
	output logic              pop,
	output logic              alias_valid,
	output logic [7:0]        alias_byte,
	output logic              alias_end,
	output logic              was_aliased,
	output logic              name_truncated
);
	import dsna_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_DIG  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0]                st_q;
	logic [OUT_MAX-1:0][7:0]   obuf_q;
	logic [3:0]                n_q;
	logic [3:0]                idx_q;
	logic                      aliased_q;
	logic                      trunc_q;
	logic [63:0]               seed_q;
	logic [20:0]               rem_q;
	logic [2:0]                cnt_q;
	logic [1:0]                dig_q;

	logic                      valid_q;
	logic [7:0]                byte_q;
	logic                      end_q;
	logic                      was_q;
	logic                      trc_q;

	logic [63:0]               seed_sel;
	logic [OUT_MAX-1:0][7:0]   alias_buf;
	logic [20:0]               modv;
	logic [42:0]               mprod;
	logic [8:0]                mquo;
	logic [12:0]               mres;
	logic [37:0]               prod;
	logic [15:0]               quo;
	logic [5:0]                dig;
	logic                      last;

	assign pop = (st_q == ST_IDLE) && avail;

	always_comb begin
		if (desc.identity != 64'd0)  seed_sel = desc.identity;
		else if (desc.hash != 64'd0) seed_sel = desc.hash;
		else                         seed_sel = 64'd1;

		// tilde form skeleton; slots 4..7 get the digits later
		for (int k = 0; k < 3; k++) begin
			alias_buf[k] = (2'(k) < desc.base_n) ? desc.base_c[k] : CH_USCR;
		end
		alias_buf[3]   = CH_TILDE;
		alias_buf[7:4] = '0;
		alias_buf[8]   = CH_DOT;
		for (int k = 0; k < 3; k++) begin
			alias_buf[9 + k] = desc.ext_c[k];
		end

		// (seed >> 8) mod 6561, one byte per step, top byte first
		modv  = {rem_q[12:0], seed_q[63:56]};
		mprod = 43'(modv) * 43'(RECIP6561);
		mquo  = mprod[42:34];
		mres  = 13'(modv - 21'(mquo) * MOD_HI);

		// x/36 = (x>>2)/9 by reciprocal, remainder is the digit
		prod = 38'(rem_q[20:2]) * 38'(RECIP9);
		quo  = prod[37:22];
		dig  = 6'(rem_q - ({5'd0, quo} << 5) - ({5'd0, quo} << 2));

		last = (idx_q == n_q - 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			obuf_q    <= '0;
			n_q       <= '0;
			idx_q     <= '0;
			aliased_q <= 1'b0;
			trunc_q   <= 1'b0;
			seed_q    <= '0;
			rem_q     <= '0;
			cnt_q     <= '0;
			dig_q     <= '0;
			valid_q   <= 1'b0;
			byte_q    <= '0;
			end_q     <= 1'b0;
			was_q     <= 1'b0;
			trc_q     <= 1'b0;
		end else begin
			valid_q <= (st_q == ST_EMIT);
			unique case (st_q)
				ST_IDLE: begin
					if (avail) begin
						trunc_q   <= desc.trunc;
						aliased_q <= !desc.fits;
						idx_q     <= '0;
						if (desc.fits) begin
							obuf_q <= desc.chars;
							n_q    <= desc.n83;
							st_q   <= ST_EMIT;
						end else begin
							obuf_q <= alias_buf;
							n_q    <= (desc.ext_n != 2'd0) ? (4'd9 + {2'd0, desc.ext_n}) : 4'd8;
							seed_q <= seed_sel;
							rem_q  <= '0;
							cnt_q  <= '0;
							st_q   <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					seed_q <= seed_q << 8;
					cnt_q  <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						// residue times 256 plus the untouched low byte
						rem_q <= {mres, seed_q[55:48]};
						dig_q <= '0;
						st_q  <= ST_DIG;
					end else begin
						rem_q <= {8'd0, mres};
					end
				end
				ST_DIG: begin
					// least significant digit first, into slots 7 down to 4
					obuf_q[4'd7 - {2'd0, dig_q}] <= digit36(dig);
					rem_q <= {5'd0, quo};
					dig_q <= dig_q + 2'd1;
					if (dig_q == 2'd3) st_q <= ST_EMIT;
				end
				ST_EMIT: begin
					byte_q  <= obuf_q[idx_q];
					end_q   <= last;
					was_q   <= aliased_q;
					trc_q   <= trunc_q;
					idx_q   <= idx_q + 4'd1;
					if (last) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign alias_valid    = valid_q;
	assign alias_byte     = byte_q;
	assign alias_end      = end_q;
	assign was_aliased    = was_q;
	assign name_truncated = trc_q;

endmodule

// ===== rtl/core/dos_short_name_alias_unit.sv =====
// Short (8.3) alias generator. A long file name is sent one byte per request
// (start high while busy is low), with name_end on the last byte and the
// entry identity sampled alongside it. The front end takes one byte every
// cycle, hashing and classifying on the fly, and only raises busy while two
// finished names are already queued for the back end. The back end emits
// the short name one character per cycle on alias_byte, flagged by
// alias_valid for exactly one cycle each; there is no way to stall it, so
// the receiver must take every character as it comes. alias_end marks the
// last character of a name, was_aliased tells the tilde form from a name
// that was already 8.3, and name_truncated flags a name longer than
// MAX_NAME bytes. Per name, the back end dispatches an 8.3 name straight
// to emission; an aliased name first reduces the 64-bit seed modulo 36^4
// a byte at a time and then forms the four base-36 digits before its
// first character, then emits 8 to 12 characters. After the back end picks
// up a name, its characters pass through the EMIT state and the output
// register, and consecutive names never share a cycle.
// The front end overlaps loading of the next name with this.
module dos_short_name_alias_unit #(
	parameter int MAX_NAME = dsna_pkg::MAX_NAME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  name_byte,
	input  logic        name_end,
	input  logic [63:0] entry_identity,
	output logic        alias_valid,
	output logic [7:0]  alias_byte,
	output logic        alias_end,
	output logic        was_aliased,
	output logic        name_truncated
);
	import dsna_pkg::*;

	logic  take;
	logic  push;
	logic  pop;
	logic  q_full;
	logic  q_avail;
	desc_t f_desc;
	desc_t b_desc;

	// a request lands whenever the queue has room for a finished name
	assign busy = q_full;
	assign take = start && !busy;

	dsna_front #(
		.MAX_NAME(MAX_NAME)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.name_byte      (name_byte),
		.name_end       (name_end),
		.entry_identity (entry_identity),
		.push           (push),
		.desc           (f_desc)
	);

	// two classified names may wait between front and back
	dsna_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (f_desc),
		.pop       (pop),
		.full      (q_full),
		.avail     (q_avail),
		.pop_data  (b_desc)
	);

	// suffix arithmetic and character emission
	dsna_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.avail          (q_avail),
		.desc           (b_desc),
		.pop            (pop),
		.alias_valid    (alias_valid),
		.alias_byte     (alias_byte),
		.alias_end      (alias_end),
		.was_aliased    (was_aliased),
		.name_truncated (name_truncated)
	);

`ifndef SYNTHESIS
	// a short name goes out in one unbroken burst
	a_burst_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		alias_valid && !alias_end |=> alias_valid)
		else $error("gap inside a short name");

	// flags stay fixed across the characters of one name
	a_flags_stable: assert property (@(posedge clk) disable iff (!arst_n)
		alias_valid && !alias_end |=> $stable(was_aliased) && $stable(name_truncated))
		else $error("name flags changed mid-name");

	// two names never run together
	a_gap_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		alias_valid && alias_end |=> !alias_valid)
		else $error("next name started without a gap");

	// an overlong name can never pass as 8.3
	a_trunc_aliased: assert property (@(posedge clk) disable iff (!arst_n)
		alias_valid && name_truncated |-> was_aliased)
		else $error("truncated name emitted in 8.3 form");
`endif

endmodule

// ===== tb/sv/dos_short_name_alias_unit_test.sv =====
`timescale 1ns / 1ps

// Tracks what the alias unit should emit. Bytes accepted by the unit are fed
// in as they go; on the last byte of a name the expected short name is worked
// out and queued, one entry per character.
class alias_scoreboard #(int CAP = 128);
	localparam logic [63:0] FNV_OFFSET = 64'd1469598103934665603;
	localparam logic [63:0] FNV_PRIME  = 64'd1099511628211;
	localparam logic [63:0] SEED_MOD   = 64'd1679616;
	localparam logic [7:0]  DOT        = 8'h2E;
	localparam logic [7:0]  TILDE      = 8'h7E;
	localparam logic [7:0]  PAD        = 8'h5F;
	localparam int          BASE_LIMIT = 8;
	localparam int          EXT_LIMIT  = 3;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       tilde;
		logic       trunc;
	} alias_char_t;

	alias_char_t expected_chars[$];
	int unsigned errors = 0;

	logic [7:0]  store [CAP];
	int unsigned name_len = 0;
	logic [63:0] fnv = FNV_OFFSET;
	int unsigned dot_at = 0;
	int unsigned dot_count = 0;
	logic        truncated = 1'b0;
	string       digit_set = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	function logic [7:0] upcase(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
	endfunction

	function bit legal(input logic [7:0] b);
		logic [7:0] u;
		u = upcase(b);
		if ((u >= 8'h41 && u <= 8'h5A) || (u >= 8'h30 && u <= 8'h39) || u[7])
			return 1'b1;
		case (u)
			8'h24, 8'h25, 8'h27, 8'h2D, 8'h5F, 8'h40, 8'h7E, 8'h60,
			8'h21, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5E, 8'h23, 8'h26: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	function void take_name_byte(input logic [7:0] b, input logic last,
			input logic [63:0] id);
		logic [7:0]  outc[$];
		logic [7:0]  c;
		logic [63:0] seed;
		int unsigned i, base_n, ext_n, stem_len, suffix, div;
		bit          ok, fits;
		alias_char_t e;

		fnv = (fnv ^ {56'd0, upcase(b)}) * FNV_PRIME;
		if (name_len < CAP) begin
			store[name_len] = b;
			if (b == DOT) begin
				dot_at = name_len;
				if (dot_count < 2) dot_count++;
			end
			name_len++;
		end else begin
			truncated = 1'b1;
		end
		if (!last) return;

		fits = 1'b0;
		if (dot_count <= 1) begin
			base_n = 0;
			ext_n  = 0;
			ok     = 1'b1;
			for (i = 0; i < name_len; i++) begin
				c = store[i];
				if (c == DOT) continue;
				if (!legal(c)) ok = 1'b0;
				if (dot_count != 0 && i > dot_at) ext_n++;
				else base_n++;
			end
			fits = ok && base_n >= 1 && base_n <= BASE_LIMIT && ext_n <= EXT_LIMIT;
			if (fits) begin
				// empty extension drops the dot
				for (i = 0; i < name_len; i++) begin
					if (store[i] == DOT) begin
						if (ext_n != 0) outc.push_back(DOT);
					end else begin
						outc.push_back(upcase(store[i]));
					end
				end
			end
		end

		if (!fits) begin
			// a dot at position zero does not split off a base
			stem_len = (dot_count != 0 && dot_at != 0) ? dot_at : name_len;
			for (i = 0; i < stem_len && outc.size() < 3; i++)
				if (legal(store[i])) outc.push_back(upcase(store[i]));
			while (outc.size() < 3) outc.push_back(PAD);
			outc.push_back(TILDE);
			seed   = (id != 0) ? id : ((fnv != 0) ? fnv : 64'd1);
			suffix = 32'(seed % SEED_MOD);
			div    = 46656;
			for (i = 0; i < 4; i++) begin
				outc.push_back(digit_set[(suffix / div) % 36]);
				div /= 36;
			end
			if (dot_count != 0 && dot_at + 1 < name_len) begin
				outc.push_back(DOT);
				ext_n = 0;
				for (i = dot_at + 1; i < name_len && ext_n < EXT_LIMIT; i++) begin
					if (legal(store[i])) begin
						outc.push_back(upcase(store[i]));
						ext_n++;
					end
				end
				if (ext_n == 0) void'(outc.pop_back());
			end
		end

		foreach (outc[k]) begin
			e.ch    = outc[k];
			e.last  = (k == outc.size() - 1);
			e.tilde = !fits;
			e.trunc = truncated;
			expected_chars.push_back(e);
		end

		name_len  = 0;
		fnv       = FNV_OFFSET;
		dot_at    = 0;
		dot_count = 0;
		truncated = 1'b0;
	endfunction

	function void check_alias_char(input logic [7:0] ch, input logic last,
			input logic tilde, input logic trunc);
		alias_char_t e;
		if (expected_chars.size() == 0) begin
			$error("unexpected alias character %h", ch);
			errors++;
			return;
		end
		e = expected_chars.pop_front();
		if (ch !== e.ch) begin
			$error("alias_byte: expected %h, got %h", e.ch, ch);
			errors++;
		end
		if (last !== e.last) begin
			$error("alias_end: expected %b, got %b", e.last, last);
			errors++;
		end
		if (tilde !== e.tilde) begin
			$error("was_aliased: expected %b, got %b", e.tilde, tilde);
			errors++;
		end
		if (trunc !== e.trunc) begin
			$error("name_truncated: expected %b, got %b", e.trunc, trunc);
			errors++;
		end
	endfunction
endclass

module dos_short_name_alias_unit_test;
	localparam int NAME_CAP     = 128;
	// total bytes to send, directed names included
	localparam int ITEM_TARGET  = 220;
	// no request and no character for this many cycles means a hang; the
	// front end can hold two names queued while the back end works, so this
	// is generous
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 200;

	typedef logic [7:0] name_q_t[$];

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  name_byte;
	logic        name_end;
	logic [63:0] entry_identity;
	logic        alias_valid;
	logic [7:0]  alias_byte;
	logic        alias_end;
	logic        was_aliased;
	logic        name_truncated;

	alias_scoreboard #(NAME_CAP) sb;
	int unsigned bytes_sent;
	int unsigned quiet_cycles;

	dos_short_name_alias_unit #(.MAX_NAME(NAME_CAP)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.name_byte     (name_byte),
		.name_end      (name_end),
		.entry_identity(entry_identity),
		.alias_valid   (alias_valid),
		.alias_byte    (alias_byte),
		.alias_end     (alias_end),
		.was_aliased   (was_aliased),
		.name_truncated(name_truncated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// characters are strobed for one cycle only; take each one at the edge
	always @(posedge clk) begin
		if (arst_n && alias_valid === 1'b1)
			sb.check_alias_char(alias_byte, alias_end, was_aliased, name_truncated);
	end

	// hang detector: counts cycles where neither side moves anything
	always @(posedge clk) begin
		if (arst_n && ((start && busy === 1'b0) || alias_valid === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// any_byte widens the mix to the full byte range
	function automatic logic [7:0] rand_char(input bit any_byte);
		string       extras;
		string       bad;
		int unsigned r;
		extras = "$%'-_@~`!(){}^#&";
		bad    = " +,;=[]*?/<>|:";
		r      = $urandom_range(0, 19);
		if (r < 4) return 8'(8'h61 + $urandom_range(0, 25));
		if (r < 8) return 8'(8'h41 + $urandom_range(0, 25));
		if (r < 11) return 8'(8'h30 + $urandom_range(0, 9));
		if (r < 14) return extras[$urandom_range(0, extras.len() - 1)];
		if (r < 16) return 8'($urandom_range(8'h80, 8'hFF));
		if (r < 17) return bad[$urandom_range(0, bad.len() - 1)];
		if (any_byte) return 8'($urandom_range(0, 255));
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	// base[.ext] shapes reach both the 8.3 and the tilde paths; the rest is
	// dot-heavy or plain noise
	function automatic name_q_t random_name();
		name_q_t     q;
		int unsigned r, n;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
			repeat (n) q.push_back(rand_char(1'b0));
			if ($urandom_range(0, 9) < 7) begin
				q.push_back(8'h2E);
				repeat ($urandom_range(0, 4)) q.push_back(rand_char(1'b0));
			end
		end else if (r < 8) begin
			repeat ($urandom_range(1, 6))
				q.push_back(($urandom_range(0, 1) == 0) ? 8'h2E : rand_char(1'b0));
		end else begin
			repeat ($urandom_range(1, 14)) q.push_back(rand_char(1'b1));
		end
		return q;
	endfunction

	// holds the request until the unit takes it, then logs it
	task automatic send_byte(input logic [7:0] b, input logic last, input logic [63:0] id);
		@(negedge clk);
		start          = 1'b1;
		name_byte      = b;
		name_end       = last;
		entry_identity = id;
		do @(posedge clk); while (busy !== 1'b0);
		sb.take_name_byte(b, last, id);
		bytes_sent++;
	endtask

	// drops start for the gap given by n, scrambling the idle payload
	task automatic pause(input int unsigned n);
		if (n == 0) return;
		@(negedge clk);
		start          = 1'b0;
		name_byte      = 8'($urandom);
		name_end       = 1'($urandom);
		entry_identity = rand64();
		repeat (n - 1) @(negedge clk);
	endtask

	// identity only matters on the last byte; earlier ones carry junk
	task automatic send_name(input name_q_t q, input logic [63:0] id);
		bit steady;
		steady = ($urandom_range(0, 3) == 0);
		foreach (q[i]) begin
			send_byte(q[i], i == q.size() - 1, (i == q.size() - 1) ? id : rand64());
			if (!steady) pause(gap_len());
		end
	endtask

	task automatic send_text(input string s, input logic [63:0] id);
		name_q_t q;
		foreach (s[i]) q.push_back(s[i]);
		send_name(q, id);
	endtask

	initial begin
		name_q_t     q;
		logic [63:0] id;

		sb             = new;
		bytes_sent     = 0;
		quiet_cycles   = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		name_byte      = 8'h00;
		name_end       = 1'b0;
		entry_identity = 64'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single char with hash seed, full 8.3, empty extension,
		// dot-only names, leading dot, two dots, a long name with spaces
		send_text("a", 64'd0);
		send_text("README.TXT", 64'hFFFF_FFFF_FFFF_FFFF);
		send_text("abc.", 64'd1);
		send_text(".", 64'd0);
		send_text("..", 64'h8000_0000_0000_0000);
		send_text(".bashrc", 64'd0);
		send_text("Long File.html", rand64());
		send_text("a.b.c", 64'd0);
		send_text("abcdefgh.ij", 64'd0);
		send_text("q.??", 64'd0);

		// zero byte, top byte and DEL in one name
		q = '{8'h00, 8'hFF, 8'h7F};
		send_name(q, 64'd0);

		// overlong: 130 bytes, dot inside the stored part, rest dropped
		q.delete();
		repeat (60) q.push_back(8'h62);
		q.push_back(8'h2E);
		repeat (69) q.push_back(8'h63);
		send_name(q, 64'd0);

		// random names until the byte budget is spent
		while (bytes_sent < ITEM_TARGET) begin
			q = random_name();
			case ($urandom_range(0, 7))
				0, 1:    id = 64'd0;
				2:       id = 64'hFFFF_FFFF_FFFF_FFFF;
				default: id = rand64();
			endcase
			send_name(q, id);
			pause(gap_len());
		end
		pause(1);

		// the hang detector covers a drain that never finishes
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.expected_chars.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
